### sv/spc_pkg.sv
// Shared types and constants of the SplitMix page pattern checker.
// No dependencies; every other file of the block imports this package.
package spc_pkg;

   // SplitMix64 constants.
   localparam logic [63:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MIX_MUL_B    = 64'h94D049BB133111EB;
   localparam int unsigned MIX_SHIFT_0  = 30;
   localparam int unsigned MIX_SHIFT_1  = 27;
   localparam int unsigned MIX_SHIFT_2  = 31;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_SEED  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMPARE_LIMIT = 1'd1;
   localparam int unsigned LIMIT_W = 17;

   // Operation codes.
   localparam logic OP_FILL   = 1'b0;
   localparam logic OP_VERIFY = 1'b1;

   // Page status codes.
   localparam logic [1:0] PAGE_PASS     = 2'd0;
   localparam logic [1:0] PAGE_MISMATCH = 2'd1;
   localparam logic [1:0] PAGE_OVERRUN  = 2'd2;

   typedef enum logic [0:0] {
      TOP_IDLE,
      TOP_BUSY
   } top_state_type;

   typedef enum logic [2:0] {
      MX_IDLE,
      MX_MUL0,
      MX_MUL1,
      MX_MUL2,
      MX_POST,
      MX_DONE
   } mix_state_type;

   typedef enum logic [1:0] {
      PH_PAGE,
      PH_MIXA,
      PH_MIXB
   } mix_phase_type;

   typedef struct packed {
      logic start;
      logic ack;
   } mix_ctrl_type;

endpackage

### sv/spc_mixer.sv
// Iterative SplitMix64 block word generator built around one 32x32 multiplier.
// Depends on spc_pkg for constants, the sequencer enums and the control struct.
module spc_mixer import spc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  mix_ctrl_type ctrl,
   input  logic [63:0]  page,
   input  logic [63:0]  seed,
   input  logic [63:0]  block_index,
   output logic         done,
   output logic [63:0]  word
);

   mix_state_type state_ff, state_in;
   mix_phase_type phase_ff, phase_in;
   logic [63:0]   opnd_ff, opnd_in;
   logic [63:0]   acc_ff, acc_in;
   logic [63:0]   word_ff, word_in;
   logic [63:0]   mul_const;
   logic [31:0]   mul_x, mul_y;
   logic [63:0]   prod;
   logic [63:0]   pre_mix;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         MX_IDLE: if (ctrl.start) state_in = MX_MUL0;
         MX_MUL0: state_in = MX_MUL1;
         MX_MUL1: state_in = MX_MUL2;
         MX_MUL2: state_in = MX_POST;
         MX_POST: state_in = (phase_ff == PH_MIXB) ? MX_DONE : MX_MUL0;
         MX_DONE: if (ctrl.ack) state_in = MX_IDLE;
         default: state_in = MX_IDLE;
      endcase
   end

   // Outputs of the sequencer: operand selection for the shared multiplier.
   always_comb begin
      case (phase_ff)
         PH_PAGE: mul_const = GOLDEN_GAMMA;
         PH_MIXA: mul_const = MIX_MUL_A;
         PH_MIXB: mul_const = MIX_MUL_B;
         default: mul_const = GOLDEN_GAMMA;
      endcase
      mul_x = (state_ff == MX_MUL2) ? opnd_ff[63:32] : opnd_ff[31:0];
      mul_y = (state_ff == MX_MUL1) ? mul_const[63:32] : mul_const[31:0];
      done  = (state_ff == MX_DONE);
   end

   assign prod    = mul_x * mul_y;
   assign pre_mix = (seed ^ acc_ff ^ block_index) + GOLDEN_GAMMA;

   // Datapath: low 64 bits of a 64x64 product from three partial products, and the mixing step after each multiply.
   always_comb begin
      phase_in = phase_ff;
      opnd_in  = opnd_ff;
      acc_in   = acc_ff;
      word_in  = word_ff;
      case (state_ff)
         MX_IDLE: begin
            if (ctrl.start) begin
               phase_in = PH_PAGE;
               opnd_in  = page;
            end
         end
         MX_MUL0: acc_in = prod;
         MX_MUL1: acc_in = acc_ff + {prod[31:0], 32'b0};
         MX_MUL2: acc_in = acc_ff + {prod[31:0], 32'b0};
         MX_POST: begin
            case (phase_ff)
               PH_PAGE: begin
                  opnd_in  = pre_mix ^ (pre_mix >> MIX_SHIFT_0);
                  phase_in = PH_MIXA;
               end
               PH_MIXA: begin
                  opnd_in  = acc_ff ^ (acc_ff >> MIX_SHIFT_1);
                  phase_in = PH_MIXB;
               end
               default: begin
                  word_in  = acc_ff ^ (acc_ff >> MIX_SHIFT_2);
                  phase_in = PH_PAGE;
               end
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MX_IDLE;
         phase_ff <= PH_PAGE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
      opnd_ff <= opnd_in;
      acc_ff  <= acc_in;
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

### sv/splitmix_page_pattern_checker.sv
// Top level of the SplitMix page pattern checker: handshakes, page tracking
// and the result register. Depends on spc_pkg and spc_mixer.
//
// Usage. Page bytes arrive one per transfer on the req_ channel, each with
// its operation (fill or verify), the byte read back, the page number and a
// last-byte flag. Every transfer yields exactly one transfer on the rsp_
// channel carrying the expected pattern byte, the byte offset, the echoed
// data byte and, on the last byte, the page status (pass, mismatch or
// overrun). The csr_ channel writes the pattern seed and the compare limit;
// it is always ready outside reset and should only be used while idle.
//
// Timing. Each byte needs a fresh SplitMix64 word, worked out by one shared
// 32x32 multiplier: three 64-bit multiplies of three partial products each,
// plus a mixing step after each. The result becomes valid in the same cycle
// that req_ready returns, so the next transfer can land on the following
// edge; one byte is worked on at a time, and a new one is taken only once
// the last has reached the output register.
// The result sits in an output register, so the next byte can be taken
// while it waits; if the receiver stalls for longer, the finished word is
// held until the output register frees. Synchronous reset clears the
// offset, the page flags, both configuration registers and the channels.
module splitmix_page_pattern_checker import spc_pkg::*; #(
   parameter int unsigned MAX_PAGE_BYTES = 65536
) (
   input  logic                   clock,
   input  logic                   reset,
   // Configuration writes.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]            csr_wdata,
   // Page bytes in.
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_op,
   input  logic [7:0]             req_data_byte,
   input  logic [63:0]            req_page_number,
   input  logic                   req_last_byte,
   // Results out.
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_pattern_byte,
   output logic [15:0]            rsp_byte_offset,
   output logic                   rsp_first_mismatch,
   output logic [7:0]             rsp_actual_byte,
   output logic                   rsp_page_end,
   output logic [1:0]             rsp_page_status
);

   // The offset counts up to MAX_PAGE_BYTES itself and saturates there.
   localparam int unsigned CNT_W = $clog2(MAX_PAGE_BYTES + 1);
   localparam int unsigned EXT_W = (CNT_W > 16) ? CNT_W : 16;
   localparam int unsigned CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam logic [CNT_W-1:0] MAX_POS = CNT_W'(MAX_PAGE_BYTES);

   top_state_type      state_ff, state_in;
   logic [63:0]        seed_ff, seed_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [CNT_W-1:0]   offset_ff, offset_in;
   logic               mismatch_seen_ff, mismatch_seen_in;
   logic               overrun_seen_ff, overrun_seen_in;
   logic               op_ff;
   logic [7:0]         data_ff;
   logic               last_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         pattern_ff;
   logic [15:0]        offset_out_ff;
   logic               first_ff;
   logic [7:0]         actual_ff;
   logic               page_end_ff;
   logic [1:0]         status_ff;

   logic               req_fire;
   logic               finish;
   mix_ctrl_type       mix_ctrl;
   logic               mix_done;
   logic [63:0]        mix_word;

   logic [EXT_W-1:0]   pos_ext;
   logic               overrun_now;
   logic               limit_ok;
   logic               compare_en;
   logic [7:0]         expected;
   logic               first_now;
   logic               mismatch_now;
   logic [1:0]         status_now;

   assign req_fire = req_valid && req_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         TOP_IDLE: if (req_fire) state_in = TOP_BUSY;
         TOP_BUSY: if (finish) state_in = TOP_IDLE;
         default:  state_in = TOP_IDLE;
      endcase
   end

   // Handshake and sequencer control outputs. A byte completes once its word
   // is ready and the output register is free or being emptied.
   always_comb begin
      req_ready      = (state_ff == TOP_IDLE) && !reset;
      csr_ready      = !reset;
      finish         = (state_ff == TOP_BUSY) && mix_done && (!rsp_valid_ff || rsp_ready);
      mix_ctrl.start = req_fire;
      mix_ctrl.ack   = finish;
   end

   spc_mixer u_mixer (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (mix_ctrl),
      .page        (req_page_number),
      .seed        (seed_ff),
      .block_index (64'(offset_ff >> 3)),
      .done        (mix_done),
      .word        (mix_word)
   );

   // Per-byte decision. The offset register is stable for the whole of the
   // item, so it doubles as the position of the byte in flight.
   always_comb begin
      pos_ext      = EXT_W'(offset_ff);
      overrun_now  = overrun_seen_ff || (offset_ff == MAX_POS);
      limit_ok     = (limit_ff == '0) || (CMP_W'(offset_ff) < CMP_W'(limit_ff));
      expected     = mix_word[{offset_ff[2:0], 3'b000} +: 8];
      compare_en   = (op_ff == OP_VERIFY) && !mismatch_seen_ff && !overrun_now && limit_ok;
      first_now    = compare_en && (data_ff != expected);
      mismatch_now = mismatch_seen_ff || first_now;
      if (!last_ff) begin
         status_now = PAGE_PASS;
      end else if (overrun_now) begin
         status_now = PAGE_OVERRUN;
      end else if (mismatch_now) begin
         status_now = PAGE_MISMATCH;
      end else begin
         status_now = PAGE_PASS;
      end
   end

   // Page tracking and configuration.
   always_comb begin
      seed_in          = seed_ff;
      limit_in         = limit_ff;
      offset_in        = offset_ff;
      mismatch_seen_in = mismatch_seen_ff;
      overrun_seen_in  = overrun_seen_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PATTERN_SEED:  seed_in  = csr_wdata;
            CSR_COMPARE_LIMIT: limit_in = csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
      if (finish) begin
         if (last_ff) begin
            offset_in        = '0;
            mismatch_seen_in = 1'b0;
            overrun_seen_in  = 1'b0;
         end else begin
            if (offset_ff != MAX_POS) begin
               offset_in = offset_ff + CNT_W'(1);
            end
            mismatch_seen_in = mismatch_now;
            overrun_seen_in  = overrun_now;
         end
      end
      rsp_valid_in = finish || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= TOP_IDLE;
         seed_ff          <= '0;
         limit_ff         <= '0;
         offset_ff        <= '0;
         mismatch_seen_ff <= 1'b0;
         overrun_seen_ff  <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         seed_ff          <= seed_in;
         limit_ff         <= limit_in;
         offset_ff        <= offset_in;
         mismatch_seen_ff <= mismatch_seen_in;
         overrun_seen_ff  <= overrun_seen_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      if (req_fire) begin
         op_ff   <= req_op;
         data_ff <= req_data_byte;
         last_ff <= req_last_byte;
      end
      if (finish) begin
         pattern_ff    <= expected;
         offset_out_ff <= pos_ext[15:0];
         first_ff      <= first_now;
         actual_ff     <= data_ff;
         page_end_ff   <= last_ff;
         status_ff     <= status_now;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pattern_byte   = pattern_ff;
   assign rsp_byte_offset    = offset_out_ff;
   assign rsp_first_mismatch = first_ff;
   assign rsp_actual_byte    = actual_ff;
   assign rsp_page_end       = page_end_ff;
   assign rsp_page_status    = status_ff;

endmodule

### sv/spc_checker.sv
// Port-level assertions for the SplitMix page pattern checker, and the bind
// that attaches them to the top level. Depends on spc_pkg for status codes.
module spc_checker import spc_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_first_mismatch,
   input logic       rsp_page_end,
   input logic [1:0] rsp_page_status
);

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // One byte is worked on at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while a byte is in progress");

   // Only a page end carries a status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_page_end |-> rsp_page_status == PAGE_PASS)
      else $error("status reported before page end");

   // A mismatch on the last byte of a page sets the mismatch status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_page_end && rsp_first_mismatch |-> rsp_page_status == PAGE_MISMATCH)
      else $error("mismatch on last byte without mismatch status");

endmodule

bind splitmix_page_pattern_checker spc_checker u_spc_checker (.*);

### tb/splitmix_page_pattern_checker_tb.sv
// Self-checking testbench for the SplitMix page pattern checker: directed pages
// and randomised page traffic under random idling on both sides.
// Depends on spc_pkg and the splitmix_page_pattern_checker RTL.
module splitmix_page_pattern_checker_tb;
   import spc_pkg::*;

   localparam int unsigned PAGE_BYTES     = 65536;
   localparam int unsigned RANDOM_ITEMS   = 1350;
   localparam int unsigned PHASE_ITEMS    = 225;
   // Settling margin, a little more than the block takes to answer a transfer.
   localparam int unsigned SETTLE_CYCLES  = 20;
   // Longest quiet stretch of a correct run is well under this limit.
   localparam int unsigned WATCHDOG_LIMIT = 2000;

   // One expected result, field for field as the rsp_ channel carries it.
   typedef struct {
      logic [7:0]  pattern;
      logic [15:0] offset;
      logic        first;
      logic [7:0]  actual;
      logic        page_end;
      logic [1:0]  status;
   } byte_report_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_PATTERN_SEED;
   logic [63:0]            csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_op = OP_FILL;
   logic [7:0]             req_data_byte = '0;
   logic [63:0]            req_page_number = '0;
   logic                   req_last_byte = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [7:0]             rsp_pattern_byte;
   logic [15:0]            rsp_byte_offset;
   logic                   rsp_first_mismatch;
   logic [7:0]             rsp_actual_byte;
   logic                   rsp_page_end;
   logic [1:0]             rsp_page_status;

   // Mirror of the block's configuration and page state, updated on each transfer.
   logic [63:0]            seed_reg = '0;
   logic [LIMIT_W-1:0]     limit_reg = '0;
   int unsigned            cur_offset = 0;
   logic                   page_mismatch = 1'b0;
   logic                   page_overrun = 1'b0;

   byte_report_type        byte_reports[$];
   int unsigned            error_count = 0;
   logic                   req_idle = 1'b1;
   logic                   rsp_idle = 1'b1;

   splitmix_page_pattern_checker #(
      .MAX_PAGE_BYTES(PAGE_BYTES)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_data_byte      (req_data_byte),
      .req_page_number    (req_page_number),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pattern_byte   (rsp_pattern_byte),
      .rsp_byte_offset    (rsp_byte_offset),
      .rsp_first_mismatch (rsp_first_mismatch),
      .rsp_actual_byte    (rsp_actual_byte),
      .rsp_page_end       (rsp_page_end),
      .rsp_page_status    (rsp_page_status)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The SplitMix64 finaliser: add the golden gamma, then two xor-shift multiplies
   // and a closing xor-shift, all modulo 2^64.
   function automatic logic [63:0] splitmix64(input logic [63:0] x);
      logic [63:0] z;
      z = x + GOLDEN_GAMMA;
      z = (z ^ (z >> MIX_SHIFT_0)) * MIX_MUL_A;
      z = (z ^ (z >> MIX_SHIFT_1)) * MIX_MUL_B;
      return z ^ (z >> MIX_SHIFT_2);
   endfunction

   // Pattern byte at a given offset of a page under the current seed. Each block
   // of eight bytes shares one word, taken little-endian.
   function automatic logic [7:0] pattern_at(input logic [63:0] page, input int unsigned pos);
      logic [63:0] page_mix;
      logic [63:0] word;
      page_mix = page * GOLDEN_GAMMA;
      word = splitmix64(seed_reg ^ page_mix ^ {32'd0, pos >> 3});
      return word[{pos[2:0], 3'b000} +: 8];
   endfunction

   // Works out the result of one accepted byte and advances the page state.
   function automatic byte_report_type compute_byte_report(input logic op,
                                                           input logic [7:0] data,
                                                           input logic [63:0] page,
                                                           input logic last);
      byte_report_type rep;
      int unsigned     pos;
      pos = cur_offset;
      // A byte arriving at the offset ceiling marks the page as overrun; its
      // pattern is still taken at the ceiling offset.
      if (pos >= PAGE_BYTES) begin
         page_overrun = 1'b1;
      end
      rep.pattern  = pattern_at(page, pos);
      rep.offset   = pos[15:0];
      rep.first    = 1'b0;
      rep.actual   = data;
      rep.page_end = last;
      rep.status   = PAGE_PASS;
      // Only verify bytes inside the compare window are checked, and only until
      // the page has recorded a mismatch or an overrun.
      if (op == OP_VERIFY && !page_mismatch && !page_overrun &&
          (limit_reg == '0 || pos < limit_reg) && data != rep.pattern) begin
         page_mismatch = 1'b1;
         rep.first = 1'b1;
      end
      if (last) begin
         // Overrun takes priority over a mismatch.
         rep.status = page_overrun ? PAGE_OVERRUN : (page_mismatch ? PAGE_MISMATCH : PAGE_PASS);
         cur_offset = 0;
         page_mismatch = 1'b0;
         page_overrun = 1'b0;
      end else if (pos < PAGE_BYTES) begin
         cur_offset = pos + 1;
      end
      return rep;
   endfunction

   // Writes one configuration register. Only called while the block is idle.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_PATTERN_SEED) begin
         seed_reg = value;
      end else if (index == CSR_COMPARE_LIMIT) begin
         limit_reg = value[LIMIT_W-1:0];
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Offers one page byte, after a random gap while req_idle is set, and returns once it has transferred.
   // Valid is either renewed or dropped at the falling edge after the transfer,
   // so the same byte is never taken twice.
   task automatic send_byte(input logic op, input logic [7:0] data, input logic [63:0] page,
                            input logic last);
      int unsigned gap;
      gap = req_idle ? $urandom_range(0, 15) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_data_byte   <= data;
      req_page_number <= page;
      req_last_byte   <= last;
      do @(posedge clock); while (!req_ready);
      byte_reports.push_back(compute_byte_report(op, data, page, last));
   endtask

   // Stops offering bytes, waits for every outstanding result and lets the block
   // settle, so that the configuration may be changed safely afterwards.
   task automatic wait_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (byte_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s differs, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Result side: a random stall before each result while rsp_idle is set, then every transfer is
   // compared with the oldest outstanding expectation.
   initial begin : result_checker
      int unsigned     stall;
      byte_report_type want;
      while (reset) @(negedge clock);
      forever begin
         stall = rsp_idle ? $urandom_range(0, 15) : 0;
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (byte_reports.size() == 0) begin
            $display("%0t: result transfer with none outstanding, offset %0h", $time,
                     rsp_byte_offset);
            error_count++;
         end else begin
            want = byte_reports.pop_front();
            check_field("pattern_byte", 16'(want.pattern), 16'(rsp_pattern_byte));
            check_field("byte_offset", want.offset, rsp_byte_offset);
            check_field("first_mismatch", 16'(want.first), 16'(rsp_first_mismatch));
            check_field("actual_byte", 16'(want.actual), 16'(rsp_actual_byte));
            check_field("page_end", 16'(want.page_end), 16'(rsp_page_end));
            check_field("page_status", 16'(want.status), 16'(rsp_page_status));
         end
      end
   end

   // Watchdog: ends the run if no channel has transferred for too long.
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
   end

   // Fill mode straight after reset, with the reset seed and limit. Nine bytes of
   // page zero cross a block boundary; the data alternates between all zeros and
   // all ones, which fill mode must echo but never compare.
   task automatic test_fill_after_reset();
      int unsigned k;
      for (k = 0; k < 9; k++) begin
         send_byte(OP_FILL, (k % 2 == 0) ? 8'h00 : 8'hFF, 64'd0, k == 8);
      end
   endtask

   // A verified page whose bytes all match, under an all-ones seed and page number.
   task automatic test_verify_clean_page();
      int unsigned k;
      wait_until_drained();
      write_csr(CSR_PATTERN_SEED, '1);
      write_csr(CSR_COMPARE_LIMIT, 64'd0);
      for (k = 0; k < 3; k++) begin
         send_byte(OP_VERIFY, pattern_at('1, cur_offset), '1, k == 2);
      end
   endtask

   // Only the first mismatch of a page is flagged; a later wrong byte is not, and
   // a fill byte in between does not clear the recorded mismatch.
   task automatic test_first_mismatch_only();
      send_byte(OP_VERIFY, pattern_at(64'd1, cur_offset) ^ 8'hFF, 64'd1, 1'b0);
      send_byte(OP_VERIFY, pattern_at(64'd1, cur_offset) ^ 8'h01, 64'd1, 1'b0);
      send_byte(OP_FILL, 8'hA5, 64'd1, 1'b0);
      send_byte(OP_VERIFY, pattern_at(64'd1, cur_offset), 64'd1, 1'b1);
   endtask

   // Every byte uses its own page number, even when it changes in mid-page.
   task automatic test_page_number_change();
      logic [63:0] page_a;
      logic [63:0] page_b;
      page_a = 64'h0123_4567_89AB_CDEF;
      page_b = ~page_a;
      send_byte(OP_VERIFY, pattern_at(page_a, cur_offset), page_a, 1'b0);
      send_byte(OP_VERIFY, pattern_at(page_b, cur_offset), page_b, 1'b0);
      send_byte(OP_VERIFY, pattern_at(page_a, cur_offset), page_a, 1'b1);
   endtask

   // The compare window: bytes at or beyond the limit are not compared, a limit
   // above the page length compares the whole page, and a limit of one catches a
   // mismatch on a single-byte page.
   task automatic test_compare_limit();
      logic [63:0] page;
      page = 64'h8000_0000_0000_0000;
      wait_until_drained();
      write_csr(CSR_COMPARE_LIMIT, 64'd2);
      send_byte(OP_VERIFY, pattern_at(page, cur_offset), page, 1'b0);
      send_byte(OP_VERIFY, pattern_at(page, cur_offset), page, 1'b0);
      send_byte(OP_VERIFY, pattern_at(page, cur_offset) ^ 8'h80, page, 1'b0);
      send_byte(OP_VERIFY, pattern_at(page, cur_offset) ^ 8'h7F, page, 1'b1);
      wait_until_drained();
      write_csr(CSR_COMPARE_LIMIT, 64'd65536);
      page = {$urandom, $urandom};
      send_byte(OP_VERIFY, pattern_at(page, cur_offset), page, 1'b0);
      send_byte(OP_VERIFY, pattern_at(page, cur_offset) ^ 8'h10, page, 1'b1);
      wait_until_drained();
      write_csr(CSR_COMPARE_LIMIT, 64'd1);
      send_byte(OP_VERIFY, pattern_at(page, cur_offset) ^ 8'h01, page, 1'b1);
   endtask

   // Random pages in several configuration phases. Most bytes are well-formed
   // verify traffic with the right data; the rest are wrong bytes, fill bytes,
   // random data, stray page numbers and early page ends. Now and then the sender
   // waits until every result has come back.
   task automatic test_random_traffic();
      int unsigned sent;
      int unsigned next_phase;
      int unsigned page_len;
      int unsigned k;
      int unsigned pick;
      logic [63:0] page;
      logic [63:0] item_page;
      logic [63:0] wdata;
      logic [LIMIT_W-1:0] new_limit;
      logic [7:0]  data;
      logic [7:0]  flip;
      logic        op;
      logic        last;
      sent = 0;
      next_phase = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= next_phase) begin
            wait_until_drained();
            case ($urandom_range(0, 3))
               0: wdata = '0;
               1: wdata = '1;
               default: wdata = {$urandom, $urandom};
            endcase
            write_csr(CSR_PATTERN_SEED, wdata);
            case ($urandom_range(0, 4))
               0: new_limit = '0;
               1: new_limit = 17'd65536;
               2: new_limit = LIMIT_W'($urandom_range(1, 8));
               3: new_limit = LIMIT_W'($urandom_range(1, 64));
               default: new_limit = LIMIT_W'($urandom_range(0, 65536));
            endcase
            // Bits above the limit field must be ignored by the block.
            wdata = {$urandom, $urandom};
            if ($urandom_range(0, 1) == 0) begin
               wdata = '0;
            end
            wdata[LIMIT_W-1:0] = new_limit;
            write_csr(CSR_COMPARE_LIMIT, wdata);
            next_phase = sent + PHASE_ITEMS;
         end else if ($urandom_range(0, 19) == 0) begin
            wait_until_drained();
         end
         req_idle = ($urandom_range(0, 3) != 0);
         rsp_idle = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0: page = '0;
            1: page = '1;
            2: page = 64'($urandom_range(0, 255));
            default: page = {$urandom, $urandom};
         endcase
         page_len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 200) : $urandom_range(1, 32);
         for (k = 0; k < page_len; k++) begin
            item_page = ($urandom_range(0, 31) == 0) ? {$urandom, $urandom} : page;
            pick = $urandom_range(0, 99);
            op = OP_VERIFY;
            data = pattern_at(item_page, cur_offset);
            if (pick >= 70 && pick < 80) begin
               flip = 8'($urandom_range(1, 255));
               data = data ^ flip;
            end else if (pick >= 80 && pick < 90) begin
               op = OP_FILL;
               data = 8'($urandom);
            end else if (pick >= 90) begin
               data = 8'($urandom);
            end
            last = (k == page_len - 1) || ($urandom_range(0, 49) == 0);
            send_byte(op, data, item_page, last);
            sent++;
            if (last) begin
               break;
            end
         end
      end
   endtask

   // Reset once, run the tests in turn, then wait for the last results.
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_fill_after_reset();
      test_verify_clean_page();
      test_first_mismatch_only();
      test_page_number_change();
      test_compare_limit();
      test_random_traffic();
      wait_until_drained();
      if (error_count == 0 && byte_reports.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
